### src/bdfp_pkg.sv
// bdfp_pkg: shared widths, register codes and sideband types for the ball
// deceleration forward predictor; no dependencies
package bdfp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int KT_SHIFT  = 32 - FRAC_BITS;
	localparam int T_FRAC    = 16;
	localparam int DEN_SHIFT = FRAC_BITS - 15;

	localparam int W_TAG   = 8;
	localparam int W_FIELD = 24;
	localparam int W_CFG   = 16;
	localparam int W_KT    = 32;
	localparam int W_ROOT  = 24;
	localparam int W_SQ    = 2 * W_ROOT;
	localparam int W_ST    = W_ROOT + W_CFG;
	localparam int W_KDEN  = W_CFG + DEN_SHIFT;
	localparam int W_DIST  = 32;
	localparam int W_PROD  = W_DIST + W_FIELD;
	localparam int DIV_QW  = 32;
	localparam int DIV_LN  = 4;
	localparam int W_ADDR  = 3;
	localparam int W_DATA  = 32;

	localparam logic [W_CFG-1:0] DECEL_RST = 16'd16384;
	localparam logic [W_CFG-1:0] LOOK_RST  = 16'd4369;

	// register index, taken from paddr bit 2
	localparam logic REG_DECEL = 1'b0;
	localparam logic REG_LOOK  = 1'b1;

	typedef struct packed {
		logic [W_TAG-1:0]   tag;
		logic [W_FIELD-1:0] px;
		logic [W_FIELD-1:0] py;
		logic [W_FIELD-1:0] ax;
		logic [W_FIELD-1:0] ay;
		logic               sx;
		logic               sy;
	} sb_sq_t;

	typedef struct packed {
		sb_sq_t              base;
		logic [W_ROOT-1:0]   speed;
		logic                stop;
		logic [W_ROOT-1:0]   vnew;
		logic [W_ROOT-1:0]   mdist;
	} sb_k_t;

	typedef struct packed {
		logic [W_TAG-1:0]   tag;
		logic [W_FIELD-1:0] px;
		logic [W_FIELD-1:0] py;
		logic               sx;
		logic               sy;
		logic               zero;
		logic               stop;
	} sb_o_t;

	function automatic logic [W_FIELD-1:0] sat_field(input logic [W_FIELD+9:0] x);
		logic [W_FIELD+9:0] hi;
		logic [W_FIELD+9:0] lo;
		hi = (W_FIELD+10)'(8388607);
		lo = ~hi;
		if (!x[W_FIELD+9] && x > hi)
			return hi[W_FIELD-1:0];
		else if (x[W_FIELD+9] && x < lo)
			return lo[W_FIELD-1:0];
		else
			return x[W_FIELD-1:0];
	endfunction

endpackage

### src/bdfp_sqrt_cell.sv
// bdfp_sqrt_cell: one digit of a pipelined integer square root,
// brings down two radicand bits and decides one root bit; no dependencies
module bdfp_sqrt_cell #(
	parameter int RW = 24,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  logic [2*RW-1:0] rad_in,
	input  logic [RW+1:0]   rem_in,
	input  logic [RW-1:0]   root_in,
	input  logic [SW-1:0]   sb_in,
	output logic            v_q,
	output logic [2*RW-1:0] rad_q,
	output logic [RW+1:0]   rem_q,
	output logic [RW-1:0]   root_q,
	output logic [SW-1:0]   sb_q
);

	logic [RW+3:0] rem_sh;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;

	assign rem_sh = {rem_in, rad_in[2*RW-1 -: 2]};
	assign trial  = {2'b00, root_in, 2'b01};
	assign diff   = rem_sh - trial;
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
			root_q <= {root_in[RW-2:0], ge};
			rad_q  <= {rad_in[2*RW-3:0], 2'b00};
			sb_q   <= sb_in;
		end
	end

endmodule

### src/bdfp_div_cell.sv
// bdfp_div_cell: one quotient bit of a pipelined restoring divider,
// several lanes sharing one divisor; no dependencies
module bdfp_div_cell #(
	parameter int VW = 24,
	parameter int QW = 32,
	parameter int LN = 1,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   v_in,
	input  logic [VW-1:0]          den_in,
	input  logic [LN-1:0][VW-1:0]  rem_in,
	input  logic [LN-1:0][QW-1:0]  num_in,
	input  logic [SW-1:0]          sb_in,
	output logic                   v_q,
	output logic [VW-1:0]          den_q,
	output logic [LN-1:0][VW-1:0]  rem_q,
	output logic [LN-1:0][QW-1:0]  num_q,
	output logic [SW-1:0]          sb_q
);

	logic [LN-1:0][VW:0]   r2;
	logic [LN-1:0][VW:0]   d2;
	logic [LN-1:0]         ge;
	logic [LN-1:0][VW-1:0] rem_nx;
	logic [LN-1:0][QW-1:0] num_nx;

	always_comb begin
		for (int l = 0; l < LN; l++) begin
			r2[l]     = {rem_in[l], num_in[l][QW-1]};
			d2[l]     = r2[l] - {1'b0, den_in};
			ge[l]     = r2[l] >= {1'b0, den_in};
			rem_nx[l] = ge[l] ? d2[l][VW-1:0] : r2[l][VW-1:0];
			num_nx[l] = {num_in[l][QW-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_in;
			rem_q <= rem_nx;
			num_q <= num_nx;
			sb_q  <= sb_in;
		end
	end

endmodule

### src/ball_decel_forward_predictor_unit.sv
// ball_decel_forward_predictor_unit: top level of the ball forward predictor
// uses bdfp_pkg, bdfp_sqrt_cell and bdfp_div_cell
//
// pipeline: 95 register stages from item acceptance to result_valid
// throughput: one item per cycle, set by the fully pipelined cell chains
// (24 square root cells, 32 cells for the stop distance divide, 32 cells
// for the four-lane direction divide); a stalled output freezes the pipe
// reset: all valid bits clear, decel_rate and lookahead_time load defaults
module ball_decel_forward_predictor_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// apb config port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bdfp_pkg::W_ADDR-1:0]      paddr,
	input  logic [bdfp_pkg::W_DATA-1:0]      pwdata,
	output logic [bdfp_pkg::W_DATA-1:0]      prdata,
	output logic                             pready,
	// input item
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic [bdfp_pkg::W_TAG-1:0]       object_tag,
	input  logic [bdfp_pkg::W_FIELD-1:0]     pos_x_in,
	input  logic [bdfp_pkg::W_FIELD-1:0]     pos_y_in,
	input  logic [bdfp_pkg::W_FIELD-1:0]     vel_x_in,
	input  logic [bdfp_pkg::W_FIELD-1:0]     vel_y_in,
	// result item
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [bdfp_pkg::W_TAG-1:0]       object_tag_out,
	output logic [bdfp_pkg::W_FIELD-1:0]     pos_x_out,
	output logic [bdfp_pkg::W_FIELD-1:0]     pos_y_out,
	output logic [bdfp_pkg::W_FIELD-1:0]     vel_x_out,
	output logic [bdfp_pkg::W_FIELD-1:0]     vel_y_out,
	output logic                             stopped
);

	import bdfp_pkg::*;

	localparam int RW  = W_ROOT;
	localparam int QW  = DIV_QW;
	localparam int KVW = W_KDEN;

	// whole pipe advances together unless the output register is held
	logic en;

	// config registers and their derived products
	logic [W_CFG-1:0]  decel_q;
	logic [W_CFG-1:0]  look_q;
	logic [W_KT-1:0]   kt_q;
	logic [W_DIST-1:0] ktt_q;

	// front stages: abs, squares, sum
	logic                     v_s1, v_s2, v_s3;
	sb_sq_t                   sb_s1, sb_s2, sb_s3;
	logic [W_SQ-1:0]          axx_s2, ayy_s2;
	logic [W_SQ-1:0]          sum_s3;
	logic [W_FIELD-1:0]       ax_in, ay_in;

	// square root chain
	logic [RW:0]              sq_v;
	logic [RW:0][2*RW-1:0]    sq_rad;
	logic [RW:0][RW+1:0]      sq_rem;
	logic [RW:0][RW-1:0]      sq_root;
	sb_sq_t [RW:0]            sq_sb;

	// speed stage
	logic                     v_s4;
	logic [RW-1:0]            speed_s4;
	logic                     stop_s4;
	logic [W_ST-1:0]          st_s4;
	logic [W_DIST-1:0]        ss_s4;
	sb_sq_t                   sb_s4;
	logic                     stop_nx;
	logic [W_ST-1:0]          st_diff;

	// stop distance divide chain: speed^2 / (2k)
	logic [QW:0]              kv;
	logic [QW:0][KVW-1:0]     kden;
	logic [QW:0][0:0][KVW-1:0] krem;
	logic [QW:0][0:0][QW-1:0] knum;
	sb_k_t [QW:0]             ksb;

	// distance select and direction products
	logic                     v_s5, v_s6;
	logic [W_DIST-1:0]        dist_s5;
	logic [RW-1:0]            vnew_s5, speed_s5, speed_s6;
	logic [W_FIELD-1:0]       ax_s5, ay_s5;
	sb_o_t                    sbo_s5, sbo_s6;
	logic [DIV_LN-1:0][W_PROD-1:0] prod_s6;

	// direction divide chain, lanes: vel x, vel y, pos x, pos y
	logic [QW:0]                        dv;
	logic [QW:0][RW-1:0]                dden;
	logic [QW:0][DIV_LN-1:0][RW-1:0]    drem;
	logic [QW:0][DIV_LN-1:0][QW-1:0]    dnum;
	sb_o_t [QW:0]                       dsb;

	// output register
	logic                     res_v_q;
	logic [W_TAG-1:0]         tag_q;
	logic [W_FIELD-1:0]       px_q, py_q, vx_q, vy_q;
	logic                     stop_q;

	sb_o_t                    fin;
	logic [QW-1:0]            qvx, qvy, qpx, qpy;
	logic [W_FIELD-1:0]       vx_nx, vy_nx;
	logic [W_FIELD+9:0]       sum_px, sum_py;

	assign en         = !res_v_q || result_ready;
	assign item_ready = en;

	// ---------------------------------------------------------------
	// config port, always ready, index taken from paddr bit 2
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decel_q <= DECEL_RST;
			look_q  <= LOOK_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_DECEL: decel_q <= pwdata[W_CFG-1:0];
				REG_LOOK:  look_q  <= pwdata[W_CFG-1:0];
				default:   decel_q <= decel_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DECEL: prdata = W_DATA'(decel_q);
			REG_LOOK:  prdata = W_DATA'(look_q);
			default:   prdata = '0;
		endcase
	end

	// k*t, k*t*t/2 are registered from config; the user must change config
	// only with the pipe empty, unchecked, so every item sees settled values
	always_ff @(posedge clk) begin
		kt_q  <= W_KT'(decel_q) * W_KT'(look_q);
		ktt_q <= W_DIST'(((W_KT + W_CFG)'(kt_q) * (W_KT + W_CFG)'(look_q)) >> (KT_SHIFT + 1));
	end

	// ---------------------------------------------------------------
	// front stages
	// ---------------------------------------------------------------
	assign ax_in = vel_x_in[W_FIELD-1] ? (~vel_x_in + 1'b1) : vel_x_in;
	assign ay_in = vel_y_in[W_FIELD-1] ? (~vel_y_in + 1'b1) : vel_y_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1.tag <= object_tag;
			sb_s1.px  <= pos_x_in;
			sb_s1.py  <= pos_y_in;
			sb_s1.ax  <= ax_in;
			sb_s1.ay  <= ay_in;
			sb_s1.sx  <= vel_x_in[W_FIELD-1];
			sb_s1.sy  <= vel_y_in[W_FIELD-1];
			// squared magnitudes, then their sum
			axx_s2    <= W_SQ'(sb_s1.ax) * W_SQ'(sb_s1.ax);
			ayy_s2    <= W_SQ'(sb_s1.ay) * W_SQ'(sb_s1.ay);
			sb_s2     <= sb_s1;
			sum_s3    <= axx_s2 + ayy_s2;
			sb_s3     <= sb_s2;
		end
	end

	// ---------------------------------------------------------------
	// square root: one root bit per cell, msb first
	// ---------------------------------------------------------------
	assign sq_v[0]    = v_s3;
	assign sq_rad[0]  = sum_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_sb[0]   = sb_s3;

	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		bdfp_sqrt_cell #(
			.RW (RW),
			.SW ($bits(sb_sq_t))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (sq_v[g]),
			.rad_in  (sq_rad[g]),
			.rem_in  (sq_rem[g]),
			.root_in (sq_root[g]),
			.sb_in   (sq_sb[g]),
			.v_q     (sq_v[g+1]),
			.rad_q   (sq_rad[g+1]),
			.rem_q   (sq_rem[g+1]),
			.root_q  (sq_root[g+1]),
			.sb_q    (sq_sb[g+1])
		);
	end

	// ---------------------------------------------------------------
	// speed stage: stop test, speed*t and speed^2
	// ---------------------------------------------------------------
	// ball stops inside the horizon when speed < k*t
	assign stop_nx = (W_ST'(sq_root[RW]) << KT_SHIFT) < W_ST'(kt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s4 <= sq_root[RW];
			stop_s4  <= stop_nx;
			st_s4    <= W_ST'(sq_root[RW]) * W_ST'(look_q);
			// only used when stopped, then speed < 2^16 and this fits
			ss_s4    <= W_DIST'(W_SQ'(sq_root[RW]) * W_SQ'(sq_root[RW]));
			sb_s4    <= sq_sb[RW];
		end
	end

	// moving case: distance = (speed*t - k*t*t/2) in position units
	assign st_diff = st_s4 - W_ST'(ktt_q);

	assign kv[0]        = v_s4;
	assign kden[0]      = KVW'(decel_q) << DEN_SHIFT;
	assign krem[0]      = '0;
	assign knum[0]      = ss_s4;
	assign ksb[0].base  = sb_s4;
	assign ksb[0].speed = speed_s4;
	assign ksb[0].stop  = stop_s4;
	assign ksb[0].vnew  = stop_s4 ? '0 : speed_s4 - RW'(kt_q >> KT_SHIFT);
	assign ksb[0].mdist = RW'(st_diff >> T_FRAC);

	// stop distance speed^2 / (2k); garbage when not stopped, then unused
	for (genvar g = 0; g < QW; g++) begin : g_kdiv
		bdfp_div_cell #(
			.VW (KVW),
			.QW (QW),
			.LN (1),
			.SW ($bits(sb_k_t))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (kv[g]),
			.den_in (kden[g]),
			.rem_in (krem[g]),
			.num_in (knum[g]),
			.sb_in  (ksb[g]),
			.v_q    (kv[g+1]),
			.den_q  (kden[g+1]),
			.rem_q  (krem[g+1]),
			.num_q  (knum[g+1]),
			.sb_q   (ksb[g+1])
		);
	end

	// ---------------------------------------------------------------
	// distance select, then the four products spread along direction
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= kv[QW];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s5     <= ksb[QW].stop ? knum[QW][0] : W_DIST'(ksb[QW].mdist);
			vnew_s5     <= ksb[QW].vnew;
			speed_s5    <= ksb[QW].speed;
			ax_s5       <= ksb[QW].base.ax;
			ay_s5       <= ksb[QW].base.ay;
			sbo_s5.tag  <= ksb[QW].base.tag;
			sbo_s5.px   <= ksb[QW].base.px;
			sbo_s5.py   <= ksb[QW].base.py;
			sbo_s5.sx   <= ksb[QW].base.sx;
			sbo_s5.sy   <= ksb[QW].base.sy;
			sbo_s5.zero <= ksb[QW].speed == '0;
			sbo_s5.stop <= ksb[QW].stop;

			prod_s6[0]  <= W_PROD'(vnew_s5) * W_PROD'(ax_s5);
			prod_s6[1]  <= W_PROD'(vnew_s5) * W_PROD'(ay_s5);
			prod_s6[2]  <= W_PROD'(dist_s5) * W_PROD'(ax_s5);
			prod_s6[3]  <= W_PROD'(dist_s5) * W_PROD'(ay_s5);
			speed_s6    <= speed_s5;
			sbo_s6      <= sbo_s5;
		end
	end

	// every quotient is below 2^32, so the top bits start as remainder
	assign dv[0]   = v_s6;
	assign dden[0] = speed_s6;
	assign dsb[0]  = sbo_s6;

	for (genvar l = 0; l < DIV_LN; l++) begin : g_lane
		assign drem[0][l] = prod_s6[l][W_PROD-1:QW];
		assign dnum[0][l] = prod_s6[l][QW-1:0];
	end

	for (genvar g = 0; g < QW; g++) begin : g_ddiv
		bdfp_div_cell #(
			.VW (RW),
			.QW (QW),
			.LN (DIV_LN),
			.SW ($bits(sb_o_t))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (dv[g]),
			.den_in (dden[g]),
			.rem_in (drem[g]),
			.num_in (dnum[g]),
			.sb_in  (dsb[g]),
			.v_q    (dv[g+1]),
			.den_q  (dden[g+1]),
			.rem_q  (drem[g+1]),
			.num_q  (dnum[g+1]),
			.sb_q   (dsb[g+1])
		);
	end

	// ---------------------------------------------------------------
	// output: apply signs, add offsets, saturate positions
	// ---------------------------------------------------------------
	assign fin = dsb[QW];
	assign qvx = dnum[QW][0];
	assign qvy = dnum[QW][1];
	assign qpx = dnum[QW][2];
	assign qpy = dnum[QW][3];

	// velocity quotients never exceed the new speed, below 2^24
	assign vx_nx = fin.sx ? (~qvx[W_FIELD-1:0] + 1'b1) : qvx[W_FIELD-1:0];
	assign vy_nx = fin.sy ? (~qvy[W_FIELD-1:0] + 1'b1) : qvy[W_FIELD-1:0];

	assign sum_px = {{10{fin.px[W_FIELD-1]}}, fin.px}
		+ (fin.sx ? ((W_FIELD+10)'(0) - (W_FIELD+10)'(qpx)) : (W_FIELD+10)'(qpx));
	assign sum_py = {{10{fin.py[W_FIELD-1]}}, fin.py}
		+ (fin.sy ? ((W_FIELD+10)'(0) - (W_FIELD+10)'(qpy)) : (W_FIELD+10)'(qpy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en) begin
			res_v_q <= dv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q  <= fin.tag;
			stop_q <= fin.stop;
			// zero speed: item passes through, velocity is zero already
			if (fin.zero) begin
				px_q <= fin.px;
				py_q <= fin.py;
				vx_q <= '0;
				vy_q <= '0;
			end else begin
				px_q <= sat_field(sum_px);
				py_q <= sat_field(sum_py);
				vx_q <= vx_nx;
				vy_q <= vy_nx;
			end
		end
	end

	assign result_valid   = res_v_q;
	assign object_tag_out = tag_q;
	assign pos_x_out      = px_q;
	assign pos_y_out      = py_q;
	assign vel_x_out      = vx_q;
	assign vel_y_out      = vy_q;
	assign stopped        = stop_q;

endmodule

### src/bdfp_checker.sv
// bdfp_checker: port-level checks on the ball forward predictor
// uses bdfp_pkg; bound to ball_decel_forward_predictor_unit
module bdfp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic                         stopped,
	input logic [bdfp_pkg::W_FIELD-1:0] vel_x_out,
	input logic [bdfp_pkg::W_FIELD-1:0] vel_y_out
);

	import bdfp_pkg::*;

	// a held result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// a stopped ball has no velocity left
	a_stop_vel: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && stopped |-> vel_x_out == '0 && vel_y_out == '0)
		else $error("stopped item with nonzero velocity");

	// an empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input blocked with empty output");

	// a full, stalled output blocks the input
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input taken while output stalled");

endmodule

bind ball_decel_forward_predictor_unit bdfp_checker u_bdfp_checker (.*);

### dv/tb_ball_decel_forward_predictor_unit.sv
`timescale 1ns / 1ps
// tb_ball_decel_forward_predictor_unit: self-checking bench for the ball forward predictor
// uses bdfp_pkg and ball_decel_forward_predictor_unit; checks every result against a local model or a typed one
module tb_ball_decel_forward_predictor_unit;
	import bdfp_pkg::*;

	localparam int    CYCLE_LIMIT = 400000;
	localparam int    LONG_HOLD   = 400;
	localparam int    PHASE_ITEMS = 220;
	localparam longint unsigned OFFSET_CAP = 64'd1 << 26;

	typedef struct {
		logic [W_TAG-1:0]   tag;
		logic [W_FIELD-1:0] px, py, vx, vy;
	} ball_in_t;

	typedef struct {
		logic [W_TAG-1:0]   tag;
		logic [W_FIELD-1:0] px, py, vx, vy;
		logic               stop;
	} ball_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [W_ADDR-1:0] paddr = '0;
	logic [W_DATA-1:0] pwdata = '0;
	logic [W_DATA-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [W_TAG-1:0] object_tag = '0;
	logic [W_FIELD-1:0] pos_x_in = '0, pos_y_in = '0, vel_x_in = '0, vel_y_in = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [W_TAG-1:0] object_tag_out;
	logic [W_FIELD-1:0] pos_x_out, pos_y_out, vel_x_out, vel_y_out;
	logic stopped;

	// mirror of the block's registers
	longint unsigned decel_k = DECEL_RST;
	longint unsigned look_t  = LOOK_RST;

	ball_out_t expected_balls[$];
	int  errors = 0;
	int  cycles = 0;
	int  burst_left = 0;
	bit  hold_req = 1'b0;
	bit  no_idle = 1'b0;

	// directed rows may carry an expectation typed in by hand
	bit        typed_pending = 1'b0;
	ball_out_t typed_exp;

	ball_decel_forward_predictor_unit DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard limit on the run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// floor(mag * num / den) along one axis, capped so the sum still saturates
	function automatic longint unsigned axis_offset(longint unsigned mag, longint unsigned num,
			longint unsigned den);
		longint unsigned q, r, res;
		q = mag / den;
		r = mag % den;
		if (num == 0)
			return 0;
		if (q >= OFFSET_CAP)
			return OFFSET_CAP;
		res = q * num + (r * num) / den;
		return (res > OFFSET_CAP) ? OFFSET_CAP : res;
	endfunction

	function automatic logic [W_FIELD-1:0] clamp24(longint x);
		if (x > 64'sd8388607)
			return 24'h7fffff;
		if (x < -64'sd8388608)
			return 24'h800000;
		return x[W_FIELD-1:0];
	endfunction

	function automatic ball_out_t project_ball(ball_in_t b);
		longint px, py, vx, vy;
		longint unsigned ax, ay, spd, ktf, vnew, travel, d;
		ball_out_t r;
		px = longint'($signed(b.px));
		py = longint'($signed(b.py));
		vx = longint'($signed(b.vx));
		vy = longint'($signed(b.vy));
		ax = longint'((vx < 0) ? -vx : vx);
		ay = longint'((vy < 0) ? -vy : vy);
		spd = int_sqrt(ax * ax + ay * ay);
		ktf = decel_k * look_t;
		r.tag = b.tag;
		r.stop = (spd << KT_SHIFT) < ktf;
		r.px = b.px;
		r.py = b.py;
		r.vx = b.vx;
		r.vy = b.vy;
		if (spd != 0) begin
			if (r.stop) begin
				// ball comes to rest: distance is v^2 / 2k
				vnew = 0;
				travel = (spd * spd) / (decel_k << DEN_SHIFT);
			end else begin
				vnew = spd - (ktf >> KT_SHIFT);
				travel = (spd * look_t - ((ktf * look_t) >> (KT_SHIFT + 1))) >> T_FRAC;
			end
			d = (vnew * ax) / spd;
			r.vx = W_FIELD'((vx < 0) ? -d : d);
			d = (vnew * ay) / spd;
			r.vy = W_FIELD'((vy < 0) ? -d : d);
			d = axis_offset(travel, ax, spd);
			r.px = clamp24(px + ((vx < 0) ? -longint'(d) : longint'(d)));
			d = axis_offset(travel, ay, spd);
			r.py = clamp24(py + ((vy < 0) ? -longint'(d) : longint'(d)));
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// predict at acceptance, using the registers in force at that moment
	always @(posedge clk) begin
		if (item_valid && item_ready && !typed_pending)
			expected_balls.push_back(project_ball('{object_tag, pos_x_in, pos_y_in,
				vel_x_in, vel_y_in}));
		else if (item_valid && item_ready)
			expected_balls.push_back(typed_exp);
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		ball_out_t e;
		if (result_valid && result_ready) begin
			if (expected_balls.size() == 0) begin
				report_mismatch("unexpected item", object_tag_out, 0);
			end else begin
				e = expected_balls.pop_front();
				if (object_tag_out !== e.tag) report_mismatch("tag", object_tag_out, e.tag);
				if (pos_x_out !== e.px) report_mismatch("pos_x", pos_x_out, e.px);
				if (pos_y_out !== e.py) report_mismatch("pos_y", pos_y_out, e.py);
				if (vel_x_out !== e.vx) report_mismatch("vel_x", vel_x_out, e.vx);
				if (vel_y_out !== e.vy) report_mismatch("vel_y", vel_y_out, e.vy);
				if (stopped !== e.stop) report_mismatch("stopped", stopped, e.stop);
			end
		end
	end

	// receiver: stall modes picked at random, plus one long hold
	int hold_cnt = 0;
	int rx_mode = 0;
	always @(posedge clk) begin
		if (cycles % 64 == 0)
			rx_mode = $urandom_range(0, 3);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = LONG_HOLD;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			result_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= ($urandom_range(0, 3) == 0);
				default: result_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic send_ball(ball_in_t b);
		item_valid <= 1'b1;
		object_tag <= b.tag;
		pos_x_in <= b.px;
		pos_y_in <= b.py;
		vel_x_in <= b.vx;
		vel_y_in <= b.vy;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		// bursts with random gaps between them
		if (!no_idle) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_balls.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [W_CFG-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= W_DATA'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_DECEL)
			decel_k = value;
		else
			look_t = value;
	endtask

	// mostly small magnitudes so both stopping and moving cases show up
	function automatic logic [W_FIELD-1:0] rand_field();
		logic [W_FIELD-1:0] v;
		v = W_FIELD'($urandom);
		case ($urandom_range(0, 7))
			0: return v;
			1: return 24'h7fffff;
			2: return 24'h800000;
			3: return '0;
			default: begin
				v = v >> $urandom_range(4, 22);
				return $urandom_range(0, 1) ? -v : v;
			end
		endcase
	endfunction

	initial begin
		ball_in_t rows[$];
		bit       typed[$];
		ball_in_t b;
		logic [W_CFG-1:0] k_set[6];
		logic [W_CFG-1:0] t_set[6];

		// zero velocity: passes through, stopped since k*t > 0 at reset
		rows.push_back('{8'h00, 24'h000000, 24'h000000, 24'h0, 24'h0}); typed.push_back(1);
		rows.push_back('{8'hff, 24'h7fffff, 24'h7fffff, 24'h0, 24'h0}); typed.push_back(1);
		rows.push_back('{8'h5a, 24'h800000, 24'h800000, 24'h0, 24'h0}); typed.push_back(1);
		// velocity extremes and position saturation
		rows.push_back('{8'h01, 24'h000000, 24'h000000, 24'h7fffff, 24'h0}); typed.push_back(0);
		rows.push_back('{8'h02, 24'h800000, 24'h800000, 24'h800000, 24'h800000});
		typed.push_back(0);
		rows.push_back('{8'h03, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff});
		typed.push_back(0);
		rows.push_back('{8'h04, 24'h7fffff, 24'h000000, 24'h100000, 24'h0}); typed.push_back(0);
		// tiny speeds that stop inside the horizon
		rows.push_back('{8'h05, 24'h001234, 24'hfff000, 24'h000001, 24'h0}); typed.push_back(0);
		rows.push_back('{8'h06, 24'h000000, 24'h000000, 24'hffffff, 24'h000001});
		typed.push_back(0);
		rows.push_back('{8'h07, 24'h010000, 24'h020000, 24'h000003, 24'h000004});
		typed.push_back(0);
		// around the stop boundary at reset settings
		rows.push_back('{8'h08, 24'h000000, 24'h000000, 24'd1092, 24'h0}); typed.push_back(0);
		rows.push_back('{8'h09, 24'h000000, 24'h000000, 24'd1093, 24'h0}); typed.push_back(0);
		rows.push_back('{8'h0a, 24'hff0000, 24'h000000, 24'h010000, 24'h0}); typed.push_back(0);
		rows.push_back('{8'h0b, 24'h000000, 24'h400000, 24'hff8000, 24'h008000});
		typed.push_back(0);
		rows.push_back('{8'h0c, 24'h123456, 24'hedcba9, 24'h0, 24'h800000}); typed.push_back(0);

		// decel and lookahead settings, extremes first, then a random pair, reset values last
		k_set = '{16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0, DECEL_RST};
		t_set = '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, LOOK_RST};
		k_set[4] = W_CFG'($urandom_range(1, 65535));
		t_set[4] = W_CFG'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset settings; the marker moves with the payload
		foreach (rows[i]) begin
			typed_pending <= typed[i];
			typed_exp <= '{rows[i].tag, rows[i].px, rows[i].py, rows[i].vx, rows[i].vy, 1'b1};
			send_ball(rows[i]);
		end
		typed_pending <= 1'b0;

		// random phases, each under its own settings, written while idle
		foreach (k_set[p]) begin
			drain();
			cfg_write(REG_DECEL, k_set[p]);
			cfg_write(REG_LOOK, t_set[p]);
			no_idle = (p == 2);
			if (p == 1)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				b.tag = W_TAG'($urandom);
				b.px = rand_field();
				b.py = rand_field();
				b.vx = rand_field();
				b.vy = rand_field();
				send_ball(b);
			end
		end

		item_valid <= 1'b0;
		while (expected_balls.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (errors == 0 && expected_balls.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
